// ----- sv/rmst_pkg.sv -----
// ----------------------------------------------------------------------------
// rmst_pkg: shared types and constants of the range minimum segment tree
// Holds the controller states, the command and status bundles passed
// between controller and datapath, and the fixed field widths.
// ----------------------------------------------------------------------------
package rmst_pkg;

   localparam int INDEX_WIDTH = 10;
   localparam int DATA_WIDTH  = 32;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_UPD_WALK,
      ST_QRY_WALK
   } rmst_state_type;

   typedef struct packed {
      logic capture;
      logic clear_step;
      logic start;
      logic upd_step;
      logic qry_step;
      logic load_rsp;
   } rmst_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic is_query;
      logic upd_skip;
      logic upd_last;
      logic qry_done;
      logic rsp_free;
   } rmst_status_type;

endpackage

// ----- sv/rmst_ctrl.sv -----
// ----------------------------------------------------------------------------
// rmst_ctrl: sequencer of the range minimum segment tree
// Steps through the clearing pass, then takes one transaction at a time and
// drives the datapath through an update walk or a query walk.
// ----------------------------------------------------------------------------
module rmst_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  rmst_pkg::rmst_status_type st,
   output rmst_pkg::rmst_cmd_type    cmd
);
   import rmst_pkg::*;

   rmst_state_type state_ff;
   rmst_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (st.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_START;
            end
         end
         ST_START: begin
            cmd.start = 1'b1;
            if (st.is_query) begin
               state_in = ST_QRY_WALK;
            end else if (st.upd_skip) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_UPD_WALK;
            end
         end
         ST_UPD_WALK: begin
            cmd.upd_step = 1'b1;
            if (st.upd_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_QRY_WALK: begin
            if (!st.qry_done) begin
               cmd.qry_step = 1'b1;
            end else if (st.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- sv/rmst_datapath.sv -----
// ----------------------------------------------------------------------------
// rmst_datapath: tree memory and walk registers of the segment tree
// Holds the node memory with one write and two registered read ports, the
// walk pointers, the running minimum and the result register.
// ----------------------------------------------------------------------------
module rmst_datapath #(
   parameter int TREE_NODES  = 2048,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rmst_pkg::rmst_cmd_type              cmd,
   output rmst_pkg::rmst_status_type           st,
   input  logic                                req_operation,
   input  logic [rmst_pkg::INDEX_WIDTH-1:0]    req_index_low,
   input  logic [rmst_pkg::INDEX_WIDTH-1:0]    req_index_high,
   input  logic [rmst_pkg::DATA_WIDTH-1:0]     req_new_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rmst_pkg::DATA_WIDTH-1:0]     rsp_min_value,
   output logic                                rsp_range_empty
);
   import rmst_pkg::*;

   localparam int NW = $clog2(TREE_NODES);
   localparam int VW = VALUE_WIDTH;
   localparam int PW = (NW + 1 > INDEX_WIDTH + 1) ? NW + 1 : INDEX_WIDTH + 1;
   localparam logic [PW-1:0] LEAVES_P = PW'(TREE_NODES / 2);
   localparam logic [VW-1:0] IDENT = '1;

   logic [VW-1:0] tree_mem [TREE_NODES];

   // Captured transaction
   logic                   op_ff;
   logic [INDEX_WIDTH-1:0] lo_ff;
   logic [INDEX_WIDTH-1:0] hi_ff;
   logic [VW-1:0]          val_ff;

   // Walk state
   logic [NW:0]   l_ff, l_in;
   logic [NW:0]   r_ff, r_in;
   logic [VW-1:0] acc_ff, acc_in;
   logic [NW-1:0] clr_ff;
   logic [VW-1:0] rd_a_ff, rd_b_ff;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_min_ff;
   logic                  rsp_empty_ff;

   logic [PW-1:0] lo_p, hi1_p, hi_clip_p, l_start_p, r_start_p;
   logic          walk_any;
   logic [NW:0]   l_plus, l_sib, r_dec;
   logic [VW-1:0] upd_min, sel_a, sel_b, pair_min, qry_min;
   logic          wr_en;
   logic [NW-1:0] waddr, raddr_a, raddr_b;
   logic [VW-1:0] wdata;

   // Range set-up: clip the inclusive high bound to the leaf count.
   always_comb begin
      lo_p      = PW'(lo_ff);
      hi1_p     = PW'(hi_ff) + PW'(1);
      hi_clip_p = (hi1_p > LEAVES_P) ? LEAVES_P : hi1_p;
      walk_any  = lo_p < hi_clip_p;
      l_start_p = lo_p + LEAVES_P;
      r_start_p = walk_any ? (hi_clip_p + LEAVES_P) : l_start_p;
   end

   always_comb begin
      upd_min  = (rd_a_ff < acc_ff) ? rd_a_ff : acc_ff;
      sel_a    = l_ff[0] ? rd_a_ff : IDENT;
      sel_b    = r_ff[0] ? rd_b_ff : IDENT;
      pair_min = (sel_a < sel_b) ? sel_a : sel_b;
      qry_min  = (pair_min < acc_ff) ? pair_min : acc_ff;
      l_plus   = l_ff + (NW + 1)'(l_ff[0]);
   end

   always_comb begin
      l_in   = l_ff;
      r_in   = r_ff;
      acc_in = acc_ff;
      if (cmd.start) begin
         l_in = l_start_p[NW:0];
         if (op_ff == OP_QUERY) begin
            r_in   = r_start_p[NW:0];
            acc_in = IDENT;
         end else begin
            acc_in = val_ff;
         end
      end else if (cmd.upd_step) begin
         l_in   = {1'b0, l_ff[NW:1]};
         acc_in = upd_min;
      end else if (cmd.qry_step) begin
         l_in   = {1'b0, l_plus[NW:1]};
         r_in   = {1'b0, r_ff[NW:1]};
         acc_in = qry_min;
      end
   end

   // Reads for the next step are issued from the next pointer values.
   always_comb begin
      l_sib   = l_in ^ (NW + 1)'(1);
      r_dec   = r_in - (NW + 1)'(1);
      raddr_a = (op_ff == OP_UPDATE) ? l_sib[NW-1:0] : l_in[NW-1:0];
      raddr_b = r_dec[NW-1:0];
   end

   always_comb begin
      wr_en = 1'b0;
      waddr = clr_ff;
      wdata = IDENT;
      if (cmd.clear_step) begin
         wr_en = 1'b1;
      end else if (cmd.start && op_ff == OP_UPDATE && !st.upd_skip) begin
         wr_en = 1'b1;
         waddr = l_start_p[NW-1:0];
         wdata = val_ff;
      end else if (cmd.upd_step) begin
         wr_en = 1'b1;
         waddr = l_ff[NW:1];
         wdata = upd_min;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tree_mem[waddr] <= wdata;
      end
      rd_a_ff <= tree_mem[raddr_a];
      rd_b_ff <= tree_mem[raddr_b];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_operation;
         lo_ff  <= req_index_low;
         hi_ff  <= req_index_high;
         val_ff <= VW'(req_new_value);
      end
      l_ff   <= l_in;
      r_ff   <= r_in;
      acc_ff <= acc_in;
      if (cmd.load_rsp) begin
         rsp_min_ff   <= DATA_WIDTH'(acc_ff);
         rsp_empty_ff <= lo_ff > hi_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + NW'(1);
         end
      end
   end

   always_comb begin
      st.clr_last = &clr_ff;
      st.is_query = op_ff == OP_QUERY;
      st.upd_skip = lo_p >= LEAVES_P;
      st.upd_last = l_ff[NW:1] == NW'(1);
      st.qry_done = !(l_ff < r_ff);
      st.rsp_free = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_min_value   = rsp_min_ff;
   assign rsp_range_empty = rsp_empty_ff;

   a_qry_step_in_range : assert property (@(posedge clock) disable iff (reset)
      cmd.qry_step |-> l_ff < r_ff)
      else $error("query step taken with an exhausted range");

   a_upd_below_root : assert property (@(posedge clock) disable iff (reset)
      cmd.upd_step |-> l_ff[NW:1] != '0)
      else $error("update walk went past the root");

   a_qry_min_falls : assert property (@(posedge clock) disable iff (reset)
      cmd.qry_step |=> acc_ff <= $past(acc_ff))
      else $error("running minimum rose during a query walk");

   a_no_result_overwrite : assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an untaken result");

endmodule

// ----- sv/range_min_segment_tree.sv -----
// ----------------------------------------------------------------------------
// range_min_segment_tree: range minimum segment tree
// Top level joining the sequencer and the tree datapath.
// ----------------------------------------------------------------------------
// The block keeps a binary segment tree of TREE_NODES words in one on-chip
// memory, with leaves at nodes TREE_NODES/2 onwards and the root at node one.
// After reset it runs a clearing pass that writes all ones into every
// node; no transaction is accepted during that pass. An update
// transaction writes the new value at its leaf and walks up to the root,
// reading one sibling and writing one parent in each cycle; the next
// transaction is taken once the walk has written the root, and an
// update produces no result. A position beyond the leaves is dropped
// without a walk. A query transaction walks both ends of the range up the
// tree a level per cycle, reading the two border nodes through the
// memory's two read ports. The result sits in an output register, so a
// following transaction is accepted while a result still waits to be
// taken; a query only stalls at its end if the previous result has not
// yet left. An empty range returns all ones with the empty flag set;
// positions beyond the leaves read as all ones. Each walk climbs one level
// per cycle through the registered reads of the node memory.
// ----------------------------------------------------------------------------
module range_min_segment_tree #(
   parameter int TREE_NODES  = 2048,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_operation,
   input  logic [rmst_pkg::INDEX_WIDTH-1:0] req_index_low,
   input  logic [rmst_pkg::INDEX_WIDTH-1:0] req_index_high,
   input  logic [rmst_pkg::DATA_WIDTH-1:0]  req_new_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [rmst_pkg::DATA_WIDTH-1:0]  rsp_min_value,
   output logic                             rsp_range_empty
);
   import rmst_pkg::*;

   // Commands from the sequencer and status back from the datapath.
   rmst_cmd_type    cmd;
   rmst_status_type st;

   rmst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   // The datapath holds the node memory, the walk pointers and the result
   // register that decouples the result side from the request side.
   rmst_datapath #(
      .TREE_NODES  (TREE_NODES),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .st              (st),
      .req_operation   (req_operation),
      .req_index_low   (req_index_low),
      .req_index_high  (req_index_high),
      .req_new_value   (req_new_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_min_value   (rsp_min_value),
      .rsp_range_empty (rsp_range_empty)
   );

endmodule
